// ===== hw/rtl/cqmi_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell quadratic minmod interpolator package
// Shared types, codes, the multiply step program and fixed-point helpers.
// ----------------------------------------------------------------------------
package cqmi_pkg;

  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned STEP_W      = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd35;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_MMEDGE = 2'd2;
  localparam logic [1:0] MODE_MMSIDE = 2'd3;

  // Mode masks: bit n enables a step in mode n.
  localparam logic [3:0] MM_ALL  = 4'b1111;
  localparam logic [3:0] MM_Q    = 4'b0010;
  localparam logic [3:0] MM_E    = 4'b0100;
  localparam logic [3:0] MM_S    = 4'b1000;
  localparam logic [3:0] MM_CORR = 4'b1110;
  localparam logic [3:0] MM_NONE = 4'b0000;

  typedef enum logic [5:0] {
    SRC_UP, SRC_UM, SRC_VP, SRC_VM,
    SRC_F0, SRC_F1, SRC_F2, SRC_F3,
    SRC_FX0, SRC_FX1, SRC_FX2, SRC_FX3,
    SRC_FY0, SRC_FY1, SRC_FY2, SRC_FY3,
    SRC_MMX01, SRC_MMX23, SRC_MMY02, SRC_MMY13,
    SRC_W0, SRC_W1, SRC_W2, SRC_W3,
    SRC_WX0, SRC_WX1, SRC_WY0, SRC_WY1,
    SRC_SDX, SRC_SDY, SRC_T, SRC_CX, SRC_CY
  } src_e;

  typedef enum logic [3:0] {
    DST_W0, DST_W1, DST_W2, DST_W3, DST_ACC, DST_SUM, DST_CX, DST_CY,
    DST_LO, DST_CXMM, DST_CYMM, DST_T, DST_TX, DST_RES
  } dst_e;

  typedef struct packed {
    logic [3:0] modes;
    src_e       a;
    src_e       b;
    dst_e       dst;
    logic       first;
  } step_t;

  typedef struct packed {
    logic  load_corner;
    logic  latch;
    logic  div_load_x;
    logic  div_load_y;
    logic  div_wb_x;
    logic  div_wb_y;
    logic  mul_issue;
    logic  mul_wb;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic div_done;
  } sts_t;

  function automatic step_t mk(logic [3:0] m, src_e a, src_e b, dst_e d, logic f);
    step_t s;
    s.modes = m;
    s.a     = a;
    s.b     = b;
    s.dst   = d;
    s.first = f;
    return s;
  endfunction

  // Program of Q16.16 products. Accumulating groups open with first set and
  // close with a destination that saturates the running sum.
  function automatic step_t step_rom(logic [STEP_W-1:0] idx);
    step_t s;
    s = mk(MM_NONE, SRC_UP, SRC_VP, DST_T, 1'b0);
    case (idx)
      6'd0:  s = mk(MM_ALL, SRC_UP, SRC_VP, DST_W0, 1'b0);
      6'd1:  s = mk(MM_ALL, SRC_UM, SRC_VP, DST_W1, 1'b0);
      6'd2:  s = mk(MM_ALL, SRC_UP, SRC_VM, DST_W2, 1'b0);
      6'd3:  s = mk(MM_ALL, SRC_UM, SRC_VM, DST_W3, 1'b0);
      6'd4:  s = mk(MM_ALL, SRC_F0, SRC_W0, DST_ACC, 1'b1);
      6'd5:  s = mk(MM_ALL, SRC_F1, SRC_W1, DST_ACC, 1'b0);
      6'd6:  s = mk(MM_ALL, SRC_F2, SRC_W2, DST_ACC, 1'b0);
      6'd7:  s = mk(MM_ALL, SRC_F3, SRC_W3, DST_SUM, 1'b0);
      6'd8:  s = mk(MM_Q, SRC_FX0, SRC_W0, DST_ACC, 1'b1);
      6'd9:  s = mk(MM_Q, SRC_FX1, SRC_W1, DST_ACC, 1'b0);
      6'd10: s = mk(MM_Q, SRC_FX2, SRC_W2, DST_ACC, 1'b0);
      6'd11: s = mk(MM_Q, SRC_FX3, SRC_W3, DST_CX, 1'b0);
      6'd12: s = mk(MM_Q, SRC_FY0, SRC_W0, DST_ACC, 1'b1);
      6'd13: s = mk(MM_Q, SRC_FY1, SRC_W1, DST_ACC, 1'b0);
      6'd14: s = mk(MM_Q, SRC_FY2, SRC_W2, DST_ACC, 1'b0);
      6'd15: s = mk(MM_Q, SRC_FY3, SRC_W3, DST_CY, 1'b0);
      6'd16: s = mk(MM_E, SRC_MMX01, SRC_WX0, DST_ACC, 1'b1);
      6'd17: s = mk(MM_E, SRC_MMX23, SRC_WX1, DST_CX, 1'b0);
      6'd18: s = mk(MM_E, SRC_MMY02, SRC_WY0, DST_ACC, 1'b1);
      6'd19: s = mk(MM_E, SRC_MMY13, SRC_WY1, DST_CY, 1'b0);
      6'd20: s = mk(MM_S, SRC_FX0, SRC_WX0, DST_ACC, 1'b1);
      6'd21: s = mk(MM_S, SRC_FX2, SRC_WX1, DST_LO, 1'b0);
      6'd22: s = mk(MM_S, SRC_FX1, SRC_WX0, DST_ACC, 1'b1);
      6'd23: s = mk(MM_S, SRC_FX3, SRC_WX1, DST_CXMM, 1'b0);
      6'd24: s = mk(MM_S, SRC_FY0, SRC_WY0, DST_ACC, 1'b1);
      6'd25: s = mk(MM_S, SRC_FY1, SRC_WY1, DST_LO, 1'b0);
      6'd26: s = mk(MM_S, SRC_FY2, SRC_WY0, DST_ACC, 1'b1);
      6'd27: s = mk(MM_S, SRC_FY3, SRC_WY1, DST_CYMM, 1'b0);
      6'd28: s = mk(MM_CORR, SRC_SDX, SRC_SDX, DST_T, 1'b0);
      6'd29: s = mk(MM_CORR, SRC_T, SRC_UP, DST_T, 1'b0);
      6'd30: s = mk(MM_CORR, SRC_T, SRC_UM, DST_T, 1'b0);
      6'd31: s = mk(MM_CORR, SRC_T, SRC_CX, DST_TX, 1'b0);
      6'd32: s = mk(MM_CORR, SRC_SDY, SRC_SDY, DST_T, 1'b0);
      6'd33: s = mk(MM_CORR, SRC_T, SRC_VP, DST_T, 1'b0);
      6'd34: s = mk(MM_CORR, SRC_T, SRC_VM, DST_T, 1'b0);
      6'd35: s = mk(MM_CORR, SRC_T, SRC_CY, DST_RES, 1'b0);
      default: s = mk(MM_NONE, SRC_UP, SRC_VP, DST_T, 1'b0);
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] sat48(logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] minmod(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [31:0] r;
    logic        [32:0] ma;
    logic        [32:0] mb;
    ma = a[31] ? 33'(-34'(a)) : 33'(a);
    mb = b[31] ? 33'(-34'(b)) : 33'(b);
    r  = '0;
    if ((a > 0 && b > 0) || (a < 0 && b < 0)) begin
      r = (ma < mb) ? a : b;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cqmi_div.sv =====
// ----------------------------------------------------------------------------
// Cell interpolator divider
// Restoring divider, one quotient bit per cycle, for the Q16.16 position ratio.
// ----------------------------------------------------------------------------
module cqmi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [31:0]        num_mag_i,
  input  logic               neg_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic [47:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rs;
  logic [33:0] diff;
  logic        ge;

  assign rs   = {rem_q, dvd_q[47]};
  assign diff = {1'b0, rs} - {2'b00, den_q};
  assign ge   = ~diff[33];

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (load_i) begin
      dvd_d = {num_mag_i, 16'h0000};
      rem_d = '0;
      cnt_d = 6'd48;
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[46:0], ge};
      rem_d = ge ? diff[31:0] : rs[31:0];
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (load_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
    end
  end

  assign done_o = (cnt_q == '0);

  always_comb begin
    if (!neg_q) begin
      quot_o = (dvd_q[47:31] != '0) ? 32'sh7fffffff : signed'(dvd_q[31:0]);
    end else begin
      quot_o = (dvd_q > 48'h0000_8000_0000) ? 32'sh80000000
                                             : signed'(-dvd_q[31:0]);
    end
  end

endmodule

// ===== hw/rtl/cqmi_dpath.sv =====
// ----------------------------------------------------------------------------
// Cell interpolator datapath
// Corner store, divider, shared Q16.16 multiplier and accumulator.
// ----------------------------------------------------------------------------
module cqmi_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cqmi_pkg::cmd_t      cmd_i,
  output cqmi_pkg::sts_t      sts_o,
  input  logic [1:0]          corner_i,
  input  logic signed [31:0]  corner_value_i,
  input  logic signed [31:0]  corner_curv_x_i,
  input  logic signed [31:0]  corner_curv_y_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  cell_min_x_i,
  input  logic signed [31:0]  cell_min_y_i,
  input  logic signed [31:0]  cell_max_x_i,
  input  logic signed [31:0]  cell_max_y_i,
  output logic signed [31:0]  result_value_o,
  output logic                bad_cell_o
);

  logic signed [31:0] f_q  [cqmi_pkg::NUM_CORNERS];
  logic signed [31:0] fx_q [cqmi_pkg::NUM_CORNERS];
  logic signed [31:0] fy_q [cqmi_pkg::NUM_CORNERS];
  logic signed [31:0] w_q  [cqmi_pkg::NUM_CORNERS];

  logic signed [32:0] ex_q, ey_q, dx_q, dy_q;
  logic signed [32:0] dx_in, dy_in;
  logic               bad_q;
  logic signed [31:0] um_q, up_q, vm_q, vp_q;
  logic signed [31:0] mul_a_q, mul_b_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] rnd;
  logic signed [31:0] qres;
  logic signed [33:0] acc_q;
  logic signed [34:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [31:0] sum_q, cx_q, cy_q, lo_q, t_q, tx_q, res_q;
  logic signed [31:0] sdx, sdy;
  logic signed [31:0] wx0, wx1, wy0, wy1;
  logic signed [33:0] corr;
  logic signed [32:0] half;
  logic signed [34:0] fin;

  logic               div_load;
  logic [31:0]        div_num;
  logic               div_neg;
  logic [31:0]        div_den;
  logic               div_done;
  logic signed [31:0] div_quot;
  logic signed [31:0] one_minus;

  assign dx_in = 33'(cell_max_x_i) - 33'(cell_min_x_i);
  assign dy_in = 33'(cell_max_y_i) - 33'(cell_min_y_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_corner) begin
      f_q[corner_i]  <= corner_value_i;
      fx_q[corner_i] <= corner_curv_x_i;
      fy_q[corner_i] <= corner_curv_y_i;
    end
    if (cmd_i.latch) begin
      ex_q <= 33'(point_x_i) - 33'(cell_min_x_i);
      ey_q <= 33'(point_y_i) - 33'(cell_min_y_i);
      dx_q <= dx_in;
      dy_q <= dy_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        bad_q <= (dx_in <= 0) || (dy_in <= 0);
      end
    end
  end

  // Divider operands: magnitude of the offset, the sign, and the cell size.
  assign div_load = cmd_i.div_load_x | cmd_i.div_load_y;
  always_comb begin
    if (cmd_i.div_load_y) begin
      div_neg = ey_q[32];
      div_num = ey_q[32] ? 32'(-ey_q) : ey_q[31:0];
      div_den = dy_q[31:0];
    end else begin
      div_neg = ex_q[32];
      div_num = ex_q[32] ? 32'(-ex_q) : ex_q[31:0];
      div_den = dx_q[31:0];
    end
  end

  cqmi_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (div_load),
    .num_mag_i (div_num),
    .neg_i     (div_neg),
    .den_i     (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign one_minus = cqmi_pkg::sat48(48'sd65536 - 48'(div_quot));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_wb_x) begin
      um_q <= div_quot;
      up_q <= one_minus;
    end
    if (cmd_i.div_wb_y) begin
      vm_q <= div_quot;
      vp_q <= one_minus;
    end
  end

  assign sdx = cqmi_pkg::sat48(48'(dx_q));
  assign sdy = cqmi_pkg::sat48(48'(dy_q));
  assign wx0 = cqmi_pkg::sat48(48'(w_q[0]) + 48'(w_q[1]));
  assign wx1 = cqmi_pkg::sat48(48'(w_q[2]) + 48'(w_q[3]));
  assign wy0 = cqmi_pkg::sat48(48'(w_q[0]) + 48'(w_q[2]));
  assign wy1 = cqmi_pkg::sat48(48'(w_q[1]) + 48'(w_q[3]));

  function automatic logic signed [31:0] src_mux(cqmi_pkg::src_e s);
    logic signed [31:0] v;
    case (s)
      cqmi_pkg::SRC_UP:    v = up_q;
      cqmi_pkg::SRC_UM:    v = um_q;
      cqmi_pkg::SRC_VP:    v = vp_q;
      cqmi_pkg::SRC_VM:    v = vm_q;
      cqmi_pkg::SRC_F0:    v = f_q[0];
      cqmi_pkg::SRC_F1:    v = f_q[1];
      cqmi_pkg::SRC_F2:    v = f_q[2];
      cqmi_pkg::SRC_F3:    v = f_q[3];
      cqmi_pkg::SRC_FX0:   v = fx_q[0];
      cqmi_pkg::SRC_FX1:   v = fx_q[1];
      cqmi_pkg::SRC_FX2:   v = fx_q[2];
      cqmi_pkg::SRC_FX3:   v = fx_q[3];
      cqmi_pkg::SRC_FY0:   v = fy_q[0];
      cqmi_pkg::SRC_FY1:   v = fy_q[1];
      cqmi_pkg::SRC_FY2:   v = fy_q[2];
      cqmi_pkg::SRC_FY3:   v = fy_q[3];
      cqmi_pkg::SRC_MMX01: v = cqmi_pkg::minmod(fx_q[0], fx_q[1]);
      cqmi_pkg::SRC_MMX23: v = cqmi_pkg::minmod(fx_q[2], fx_q[3]);
      cqmi_pkg::SRC_MMY02: v = cqmi_pkg::minmod(fy_q[0], fy_q[2]);
      cqmi_pkg::SRC_MMY13: v = cqmi_pkg::minmod(fy_q[1], fy_q[3]);
      cqmi_pkg::SRC_W0:    v = w_q[0];
      cqmi_pkg::SRC_W1:    v = w_q[1];
      cqmi_pkg::SRC_W2:    v = w_q[2];
      cqmi_pkg::SRC_W3:    v = w_q[3];
      cqmi_pkg::SRC_WX0:   v = wx0;
      cqmi_pkg::SRC_WX1:   v = wx1;
      cqmi_pkg::SRC_WY0:   v = wy0;
      cqmi_pkg::SRC_WY1:   v = wy1;
      cqmi_pkg::SRC_SDX:   v = sdx;
      cqmi_pkg::SRC_SDY:   v = sdy;
      cqmi_pkg::SRC_T:     v = t_q;
      cqmi_pkg::SRC_CX:    v = cx_q;
      cqmi_pkg::SRC_CY:    v = cy_q;
      default:             v = '0;
    endcase
    return v;
  endfunction

  // Multiplier: operands registered, then the full product registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      mul_a_q <= src_mux(cmd_i.step.a);
      mul_b_q <= src_mux(cmd_i.step.b);
    end
    prod_q <= mul_a_q * mul_b_q;
  end

  // Round to nearest with ties upward, then saturate.
  assign rnd     = prod_q + 64'sd32768;
  assign qres    = cqmi_pkg::sat48(signed'(rnd[63:16]));
  assign acc_sum = 35'(acc_q) + 35'(qres);
  assign acc_sat = cqmi_pkg::sat48(48'(acc_sum));

  // Final correction: half of both terms, rounded upward on ties.
  assign corr = 34'(tx_q) + 34'(qres) + 34'sd1;
  assign half = corr[33:1];
  assign fin  = 35'(sum_q) - 35'(half);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_wb) begin
      case (cmd_i.step.dst)
        cqmi_pkg::DST_W0:   w_q[0] <= qres;
        cqmi_pkg::DST_W1:   w_q[1] <= qres;
        cqmi_pkg::DST_W2:   w_q[2] <= qres;
        cqmi_pkg::DST_W3:   w_q[3] <= qres;
        cqmi_pkg::DST_ACC:  acc_q  <= cmd_i.step.first ? 34'(qres) : acc_sum[33:0];
        cqmi_pkg::DST_SUM: begin
          sum_q <= acc_sat;
          res_q <= acc_sat;
        end
        cqmi_pkg::DST_CX:   cx_q <= acc_sat;
        cqmi_pkg::DST_CY:   cy_q <= acc_sat;
        cqmi_pkg::DST_LO:   lo_q <= acc_sat;
        cqmi_pkg::DST_CXMM: cx_q <= cqmi_pkg::minmod(lo_q, acc_sat);
        cqmi_pkg::DST_CYMM: cy_q <= cqmi_pkg::minmod(lo_q, acc_sat);
        cqmi_pkg::DST_T:    t_q  <= qres;
        cqmi_pkg::DST_TX:   tx_q <= qres;
        cqmi_pkg::DST_RES:  res_q <= cqmi_pkg::sat48(48'(fin));
        default: ;
      endcase
    end
  end

  assign sts_o.bad      = bad_q;
  assign sts_o.div_done = div_done;

  assign result_value_o = bad_q ? 32'sd0 : res_q;
  assign bad_cell_o     = bad_q;

endmodule

// ===== hw/rtl/cqmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cell interpolator controller
// Mode register and the sequencer that drives the datapath.
// ----------------------------------------------------------------------------
module cqmi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           action_i,
  input  logic           mode_we_i,
  input  logic [1:0]     mode_i,
  input  cqmi_pkg::sts_t sts_i,
  output cqmi_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           result_valid_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_DIVX  = 8'b0000_0100,
    S_DIVY  = 8'b0000_1000,
    S_MOP   = 8'b0001_0000,
    S_MRUN  = 8'b0010_0000,
    S_MWB   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e                            state_q, state_d;
  logic [1:0]                        mode_q;
  logic [cqmi_pkg::STEP_W-1:0]       pc_q, pc_d;
  cqmi_pkg::step_t                   step;
  logic                              step_en;

  assign step    = cqmi_pkg::step_rom(pc_q);
  assign step_en = step.modes[mode_q];

  always_comb begin
    state_d           = state_q;
    pc_d              = pc_q;
    cmd_o             = '0;
    cmd_o.step        = step;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i == cqmi_pkg::ACT_EVAL) begin
            cmd_o.latch = 1'b1;
            state_d     = S_CHECK;
          end else begin
            cmd_o.load_corner = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_load_x = 1'b1;
          state_d          = S_DIVX;
        end
      end
      S_DIVX: begin
        if (sts_i.div_done) begin
          cmd_o.div_wb_x   = 1'b1;
          cmd_o.div_load_y = 1'b1;
          state_d          = S_DIVY;
        end
      end
      S_DIVY: begin
        if (sts_i.div_done) begin
          cmd_o.div_wb_y = 1'b1;
          pc_d           = '0;
          state_d        = S_MOP;
        end
      end
      S_MOP: begin
        if (step_en) begin
          cmd_o.mul_issue = 1'b1;
          state_d         = S_MRUN;
        end else if (pc_q == cqmi_pkg::LAST_STEP) begin
          state_d = S_DONE;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      S_MRUN: begin
        state_d = S_MWB;
      end
      S_MWB: begin
        cmd_o.mul_wb = 1'b1;
        if (pc_q == cqmi_pkg::LAST_STEP) begin
          state_d = S_DONE;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = S_MOP;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      mode_q  <= cqmi_pkg::MODE_LINEAR;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (mode_we_i) begin
        mode_q <= mode_i;
      end
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

`ifndef SYNTH
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == cqmi_pkg::ACT_LOAD) |=> !busy_o)
    else $error("corner load made the block busy");

  a_eval_checks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == cqmi_pkg::ACT_EVAL) |=> state_q == S_CHECK)
    else $error("evaluate transaction did not start the cell check");

  a_div_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX && sts_i.div_done) |=> state_q == S_DIVY)
    else $error("second division did not follow the first");
`endif

endmodule

// ===== hw/rtl/cell_quadratic_minmod_interpolator.sv =====
// ----------------------------------------------------------------------------
// Cell quadratic minmod interpolator
// Bilinear Q16.16 interpolation in a cell; non-linear modes correct curvature.
// ----------------------------------------------------------------------------
// Usage. An input transaction is taken at a rising edge with start high and
// busy low. A load transaction (action 0) stores the value and both curvatures
// of one corner in that cycle; busy stays low and no result follows. Every
// corner must be loaded before an evaluation reads it.
// An evaluate transaction (action 1) raises busy until its single result has
// been shown. The result is on result_value_o and bad_cell_o for exactly one
// cycle while result_valid_o is high; the receiver cannot stall it, so it must
// capture the result in that cycle.
// Sequence. A cell whose width or height is not positive goes from the check
// state straight to the done state that raises the strobe, with result_value_o
// zero. Otherwise the two position divisions run one after the other in the
// bit-serial divider, and each Q16.16 product passes through the issue, run and
// write-back states of the single shared multiplier, while every step of the
// program that the mode skips still passes through the issue state. The next
// transaction can be taken in the cycle after the result strobe.
// The user must write the mode register with mode_we_i only while the block is
// idle; the block itself does not enforce it.
// Reset clears the mode to linear and returns the sequencer to idle; the corner
// store holds no meaningful data until it is loaded.
// ----------------------------------------------------------------------------
module cell_quadratic_minmod_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_we_i,
  input  logic [1:0]         mode_i,
  input  logic               action_i,
  input  logic [1:0]         corner_i,
  input  logic signed [31:0] corner_value_i,
  input  logic signed [31:0] corner_curv_x_i,
  input  logic signed [31:0] corner_curv_y_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] cell_min_x_i,
  input  logic signed [31:0] cell_min_y_i,
  input  logic signed [31:0] cell_max_x_i,
  input  logic signed [31:0] cell_max_y_i,
  output logic               result_valid_o,
  output logic signed [31:0] result_value_o,
  output logic               bad_cell_o
);

  // Commands flow from the sequencer to the datapath, status flows back.
  cqmi_pkg::cmd_t cmd;
  cqmi_pkg::sts_t sts;

  cqmi_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .action_i       (action_i),
    .mode_we_i      (mode_we_i),
    .mode_i         (mode_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  cqmi_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .corner_i        (corner_i),
    .corner_value_i  (corner_value_i),
    .corner_curv_x_i (corner_curv_x_i),
    .corner_curv_y_i (corner_curv_y_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .cell_min_x_i    (cell_min_x_i),
    .cell_min_y_i    (cell_min_y_i),
    .cell_max_x_i    (cell_max_x_i),
    .cell_max_y_i    (cell_max_y_i),
    .result_value_o  (result_value_o),
    .bad_cell_o      (bad_cell_o)
  );

endmodule

// ===== bench/cqmi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interpolator checker
// Watches the input and result channels, predicts each evaluation and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module cqmi_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               mode_we_i,
  input  logic [1:0]         mode_i,
  input  logic               action_i,
  input  logic [1:0]         corner_i,
  input  logic signed [31:0] corner_value_i,
  input  logic signed [31:0] corner_curv_x_i,
  input  logic signed [31:0] corner_curv_y_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] cell_min_x_i,
  input  logic signed [31:0] cell_min_y_i,
  input  logic signed [31:0] cell_max_x_i,
  input  logic signed [31:0] cell_max_y_i,
  input  logic               result_valid_o,
  input  logic signed [31:0] result_value_o,
  input  logic               bad_cell_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 evals_o,
  output int                 bad_seen_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               bad;
  } interp_t;

  interp_t            expected_q[$];
  logic [1:0]         mode_copy;
  logic signed [31:0] vals[cqmi_pkg::NUM_CORNERS];
  logic signed [31:0] curv_x[cqmi_pkg::NUM_CORNERS];
  logic signed [31:0] curv_y[cqmi_pkg::NUM_CORNERS];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product rounded to nearest, ties upward.
  function automatic longint qmul(longint a, longint b);
    return sat32((a * b + 32768) >>> 16);
  endfunction

  function automatic longint mm(longint a, longint b);
    longint ma;
    longint mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if ((a > 0 && b > 0) || (a < 0 && b < 0)) return (ma < mb) ? a : b;
    return 0;
  endfunction

  function automatic interp_t interpolate(longint px, longint py, longint x0,
                                          longint y0, longint x1, longint y1);
    interp_t r;
    longint  dx, dy, um, up, vm, vp, sum, cx, cy, tx, ty, lo, hi;
    longint  wx0, wx1, wy0, wy1;
    longint  w[4];
    r.value = '0;
    r.bad   = 1'b0;
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx <= 0 || dy <= 0) begin
      r.bad = 1'b1;
      return r;
    end
    um = sat32(((px - x0) * 65536) / dx);
    up = sat32(65536 - um);
    vm = sat32(((py - y0) * 65536) / dy);
    vp = sat32(65536 - vm);
    w[0] = qmul(up, vp);
    w[1] = qmul(um, vp);
    w[2] = qmul(up, vm);
    w[3] = qmul(um, vm);
    sum = 0;
    for (int j = 0; j < 4; j++) sum += qmul(vals[j], w[j]);
    sum = sat32(sum);
    cx = 0;
    cy = 0;
    wx0 = sat32(w[0] + w[1]);
    wx1 = sat32(w[2] + w[3]);
    wy0 = sat32(w[0] + w[2]);
    wy1 = sat32(w[1] + w[3]);
    case (mode_copy)
      cqmi_pkg::MODE_QUAD: begin
        for (int j = 0; j < 4; j++) begin
          cx += qmul(curv_x[j], w[j]);
          cy += qmul(curv_y[j], w[j]);
        end
        cx = sat32(cx);
        cy = sat32(cy);
      end
      cqmi_pkg::MODE_MMEDGE: begin
        cx = sat32(qmul(mm(curv_x[0], curv_x[1]), wx0) + qmul(mm(curv_x[2], curv_x[3]), wx1));
        cy = sat32(qmul(mm(curv_y[0], curv_y[2]), wy0) + qmul(mm(curv_y[1], curv_y[3]), wy1));
      end
      cqmi_pkg::MODE_MMSIDE: begin
        lo = sat32(qmul(curv_x[0], wx0) + qmul(curv_x[2], wx1));
        hi = sat32(qmul(curv_x[1], wx0) + qmul(curv_x[3], wx1));
        cx = mm(lo, hi);
        lo = sat32(qmul(curv_y[0], wy0) + qmul(curv_y[1], wy1));
        hi = sat32(qmul(curv_y[2], wy0) + qmul(curv_y[3], wy1));
        cy = mm(lo, hi);
      end
      default: ;
    endcase
    if (mode_copy != cqmi_pkg::MODE_LINEAR) begin
      tx = qmul(qmul(qmul(qmul(sat32(dx), sat32(dx)), up), um), cx);
      ty = qmul(qmul(qmul(qmul(sat32(dy), sat32(dy)), vp), vm), cy);
      sum = sat32(sum - ((tx + ty + 1) >>> 1));
    end
    r.value = sum[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic signed [31:0] got,
                        input logic signed [31:0] want);
    $display("checker: mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    interp_t e;
    if (!rst_ni) begin
      mode_copy    <= cqmi_pkg::MODE_LINEAR;
      fail_count_o = 0;
      evals_o      = 0;
      bad_seen_o   = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (mode_we_i) mode_copy <= mode_i;
      if (start && !busy) begin
        if (action_i == cqmi_pkg::ACT_LOAD) begin
          vals[corner_i]   = corner_value_i;
          curv_x[corner_i] = corner_curv_x_i;
          curv_y[corner_i] = corner_curv_y_i;
        end else begin
          expected_q.push_back(interpolate(point_x_i, point_y_i, cell_min_x_i,
                                           cell_min_y_i, cell_max_x_i, cell_max_y_i));
          evals_o++;
        end
      end
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", result_value_o, 0);
        end else begin
          e = expected_q.pop_front();
          if (e.bad) bad_seen_o++;
          if (bad_cell_o !== e.bad) report("bad_cell", 32'(bad_cell_o), 32'(e.bad));
          if (result_value_o !== e.value) report("result_value", result_value_o, e.value);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interpolator testbench
// Loads cell corners and evaluates points in every mode, first with directed
// extremes and bad cells, then with random traffic and random sender gaps.
// ----------------------------------------------------------------------------
module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               mode_we_i = 1'b0;
  logic [1:0]         mode_i = cqmi_pkg::MODE_LINEAR;
  logic               action_i = cqmi_pkg::ACT_LOAD;
  logic [1:0]         corner_i = '0;
  logic signed [31:0] corner_value_i = '0;
  logic signed [31:0] corner_curv_x_i = '0;
  logic signed [31:0] corner_curv_y_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] cell_min_x_i = '0;
  logic signed [31:0] cell_min_y_i = '0;
  logic signed [31:0] cell_max_x_i = '0;
  logic signed [31:0] cell_max_y_i = '0;
  logic               result_valid_o;
  logic signed [31:0] result_value_o;
  logic               bad_cell_o;
  int                 fail_count;
  int                 pending;
  int                 evals;
  int                 bad_seen;
  bit                 gaps_on = 1'b1;

  // 8 ns period clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cell_quadratic_minmod_interpolator uut (.*);

  cqmi_checker chk (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .evals_o(evals),
    .bad_seen_o(bad_seen)
  );

  // Random Q16.16 values: moderate numbers half of the time so the arithmetic
  // stays in range, with zero, both extremes and raw 32-bit patterns mixed in.
  function automatic logic signed [31:0] rnd_q();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3, 4:    return $urandom();
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  // Optional random gap before a transaction.
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk_i);
  endtask

  // Drives one transaction at a falling edge once busy is low; busy only
  // changes at rising edges, so the value seen here holds at the next edge.
  task automatic send();
    while (busy) @(negedge clk_i);
    start = 1'b1;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic load_corner(input logic [1:0] c, input logic signed [31:0] v,
                             input logic signed [31:0] kx, input logic signed [31:0] ky);
    maybe_gap();
    while (busy) @(negedge clk_i);
    action_i        = cqmi_pkg::ACT_LOAD;
    corner_i        = c;
    corner_value_i  = v;
    corner_curv_x_i = kx;
    corner_curv_y_i = ky;
    point_x_i       = $urandom();
    send();
  endtask

  task automatic evaluate(input logic signed [31:0] px, input logic signed [31:0] py,
                          input logic signed [31:0] x0, input logic signed [31:0] y0,
                          input logic signed [31:0] x1, input logic signed [31:0] y1);
    maybe_gap();
    while (busy) @(negedge clk_i);
    action_i     = cqmi_pkg::ACT_EVAL;
    corner_i     = 2'($urandom());
    point_x_i    = px;
    point_y_i    = py;
    cell_min_x_i = x0;
    cell_min_y_i = y0;
    cell_max_x_i = x1;
    cell_max_y_i = y1;
    send();
  endtask

  // Mode writes happen only with the block idle: every result is in and the
  // sequencer has returned to idle before the write.
  task automatic write_mode(input logic [1:0] m);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    mode_we_i = 1'b1;
    mode_i    = m;
    @(negedge clk_i);
    mode_we_i = 1'b0;
  endtask

  // Random evaluation: usually a sensible cell with the point near it, now
  // and then raw patterns or a collapsed cell.
  task automatic random_eval();
    logic signed [31:0] x0, y0, x1, y1, px, py;
    int                 wx, wy;
    wx = $urandom_range(1, 32'h0010_0000);
    wy = $urandom_range(1, 32'h0010_0000);
    x0 = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    y0 = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    x1 = x0 + wx;
    y1 = y0 + wy;
    px = x0 + $signed($urandom_range(0, 2 * wx)) - wx / 2;
    py = y0 + $signed($urandom_range(0, 2 * wy)) - wy / 2;
    case ($urandom_range(0, 9))
      0: begin
        px = $urandom(); py = $urandom(); x0 = $urandom();
        y0 = $urandom(); x1 = $urandom(); y1 = $urandom();
      end
      1: x1 = x0 - $signed($urandom_range(0, 3));
      2: y1 = y0 - $signed($urandom_range(0, 3));
      default: ;
    endcase
    evaluate(px, py, x0, y0, x1, y1);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) load_corner(2'($urandom()), rnd_q(), rnd_q(), rnd_q());
      else random_eval();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every corner loaded first, then extremes, points on two opposite
    // corners, points outside the cell and both kinds of bad cell.
    load_corner(2'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    load_corner(2'd1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    load_corner(2'd2, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    load_corner(2'd3, -32'sh0004_0000, 32'sh0000_8000, -32'sh0001_0000);
    evaluate(32'sh0000_8000, 32'sh0000_8000, 0, 0, 32'sh0001_0000, 32'sh0001_0000);
    evaluate(0, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000);
    evaluate(32'sh0001_0000, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 32'sh0001_0000);
    evaluate(0, 0, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000);
    evaluate(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
    write_mode(cqmi_pkg::MODE_QUAD);
    load_corner(2'd0, 32'sh0003_0000, 32'sh0001_0000, 32'sh0002_0000);
    load_corner(2'd1, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
    evaluate(32'sh0000_4000, 32'sh0000_c000, 0, 0, 32'sh0002_0000, 32'sh0001_0000);
    evaluate(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff);
    write_mode(cqmi_pkg::MODE_MMEDGE);
    evaluate(32'sh0000_4000, 32'sh0000_c000, 0, 0, 32'sh0002_0000, 32'sh0001_0000);
    evaluate(32'sh7fffffff, 32'sh7fffffff, 0, 0, 1, 1);
    write_mode(cqmi_pkg::MODE_MMSIDE);
    evaluate(32'sh0000_4000, 32'sh0000_c000, 0, 0, 32'sh0002_0000, 32'sh0001_0000);
    evaluate(32'sh80000000, 32'sh0005_0000, 32'sh0001_0000, 0, 32'sh0003_0000,
             32'sh0010_0000);

    // Random phases, one per mode and side minmod mode once more; the last phase
    // runs without sender gaps.
    write_mode(cqmi_pkg::MODE_LINEAR);
    random_phase(90);
    write_mode(cqmi_pkg::MODE_MMSIDE);
    random_phase(90);
    write_mode(cqmi_pkg::MODE_QUAD);
    random_phase(90);
    write_mode(cqmi_pkg::MODE_MMEDGE);
    random_phase(90);
    gaps_on = 1'b0;
    write_mode(cqmi_pkg::MODE_MMSIDE);
    random_phase(75);

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("tb: %0d evaluations checked, %0d of them bad cells, over all four modes",
             evals, bad_seen);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cqmi_pkg.sv
hw/rtl/cqmi_div.sv
hw/rtl/cqmi_dpath.sv
hw/rtl/cqmi_ctrl.sv
hw/rtl/cell_quadratic_minmod_interpolator.sv
bench/cqmi_checker.sv
bench/tb.sv
